### design/fvpu_pkg.sv
// ----------------------------------------------------------------------------
// fvpu_pkg
// Types, constants and helpers for the face velocity pressure update.
// ----------------------------------------------------------------------------
package fvpu_pkg;

  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP_OVER_SPACING = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_SCALE     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_ON        = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_FLOOR      = 8'd3;

  localparam logic [31:0] STEP_OVER_SPACING_RESET = 32'd65536;
  localparam logic [31:0] SURFACE_SCALE_RESET     = 32'd65536;
  localparam logic [16:0] WEIGHT_FLOOR_RESET      = 17'd655;  // 0.01

  // divider: 34 quotient bits, two guard bits so each stage retires four
  localparam int DIV_STAGES     = 9;
  localparam int DIV_STEPS      = 4;
  localparam int DIV_Q_W        = DIV_STAGES * DIV_STEPS;

  typedef struct packed {
    logic               edge_face;
    logic [16:0]        open_weight;
    logic [16:0]        wet_weight;
    logic signed [31:0] old_velocity;
    logic               back_inside;
    logic signed [31:0] back_pressure;
    logic signed [31:0] back_surface_pressure;
    logic               front_inside;
    logic signed [31:0] front_pressure;
    logic signed [31:0] front_surface_pressure;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_velocity;
    logic               face_valid;
  } out_t;

  // what rides along the divider
  typedef struct packed {
    logic signed [31:0] old_velocity;
    logic               neg;
    logic               zero;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

### design/fvpu_div.sv
// ----------------------------------------------------------------------------
// fvpu_div
// Pipelined restoring divider, 65-bit dividend by 17-bit divisor; a quotient
// of 2^34 or more is flagged as ovf, four quotient bits per stage.
// ----------------------------------------------------------------------------
module fvpu_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_v,
  input  logic [64:0]               num,
  input  logic [16:0]               theta,
  input  fvpu_pkg::side_t           side_in,
  output logic                      out_v,
  output logic [fvpu_pkg::DIV_Q_W-1:0] q,
  output logic                      ovf,
  output fvpu_pkg::side_t           side_out
);
  import fvpu_pkg::*;

  typedef struct packed {
    logic [16:0]        r;
    logic [DIV_Q_W-1:0] dvd;
    logic [DIV_Q_W-1:0] q;
    logic               ovf;
    logic [16:0]        theta;
    side_t              side;
  } dstage_t;

  logic    v   [DIV_STAGES+1];
  dstage_t st  [DIV_STAGES+1];

  function automatic dstage_t div_step(input dstage_t x);
    dstage_t    y;
    logic [17:0] r2;
    y = x;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r2    = {y.r, y.dvd[DIV_Q_W-1]};
      y.dvd = {y.dvd[DIV_Q_W-2:0], 1'b0};
      if (r2 >= {1'b0, y.theta}) begin
        r2  = r2 - {1'b0, y.theta};
        y.q = {y.q[DIV_Q_W-2:0], 1'b1};
      end else begin
        y.q = {y.q[DIV_Q_W-2:0], 1'b0};
      end
      y.r = r2[16:0];
    end
    return y;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STAGES; s++) v[s] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
      for (int s = 1; s <= DIV_STAGES; s++) v[s] <= v[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // high part below theta means the quotient fits in 34 bits
      st[0].ovf   <= (num[64:34] >= {14'b0, theta});
      st[0].r     <= num[50:34];
      st[0].dvd   <= {num[33:0], 2'b00};
      st[0].q     <= '0;
      st[0].theta <= theta;
      st[0].side  <= side_in;
      for (int s = 1; s <= DIV_STAGES; s++) st[s] <= div_step(st[s-1]);
    end
  end

  assign out_v    = v[DIV_STAGES];
  assign q        = st[DIV_STAGES].q;
  assign ovf      = st[DIV_STAGES].ovf;
  assign side_out = st[DIV_STAGES].side;

endmodule

### design/face_velocity_pressure_update.sv
// ----------------------------------------------------------------------------
// face_velocity_pressure_update
// Subtracts the scaled pressure gradient from a face velocity, pipelined.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    in_data  (in_t)
// out       output     out_valid/out_ready  out_data (out_t)
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless the output stalls; 7 arithmetic stages, the
// divider's entry plus 9 stages of 4 quotient bits, and the output register.
// Reset clears valid bits and loads register defaults.
// A stall at the output freezes the whole pipeline; cfg_ready is always high.
// ----------------------------------------------------------------------------
module face_velocity_pressure_update (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fvpu_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fvpu_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fvpu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);
  import fvpu_pkg::*;

  logic [31:0]        sos;
  logic signed [31:0] scale;
  logic               son;
  logic [16:0]        wfloor;

  logic en;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sos    <= STEP_OVER_SPACING_RESET;
      scale  <= SURFACE_SCALE_RESET;
      son    <= 1'b0;
      wfloor <= WEIGHT_FLOOR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STEP_OVER_SPACING: sos    <= cfg_data;
        REG_SURFACE_SCALE:     scale  <= cfg_data;
        REG_SURFACE_ON:        son    <= cfg_data[0];
        REG_WEIGHT_FLOOR:      wfloor <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // stage registers
  logic v1, v2, v3, v4, v5, v6, v7;
  in_t                d1;
  logic [16:0]        th1, th2, th3, th4, th5, th6, th7;
  logic               z1;
  side_t              sd2, sd3, sd4, sd5, sd6, sd7;
  logic               bin2, fin2, bin3, fin3, bin4, fin4;
  logic signed [31:0] bp2, fp2, bp3, fp3, bp4, fp4;
  logic signed [49:0] ba2, bb2, fa2, fb2;
  logic signed [31:0] bl3, fl3;
  logic signed [63:0] bm4, fm4;
  logic [32:0]        mag5;
  logic [48:0]        plo6, phi6;
  logic [64:0]        num7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  logic signed [17:0] wgt1, th1s;
  assign th1s = $signed({1'b0, th1});
  assign wgt1 = 18'sd65536 - th1s;

  logic signed [50:0] sumb, sumf;
  assign sumb = 51'(ba2) + 51'(bb2);
  assign sumf = 51'(fa2) + 51'(fb2);

  logic signed [31:0] sb4, sf4, pb4, pf4;
  logic signed [32:0] d4;
  assign sb4 = sat32(64'(bm4 >>> 16));
  assign sf4 = sat32(64'(fm4 >>> 16));
  assign pb4 = bin4 ? bp4 : (son ? sb4 : 32'sd0);
  assign pf4 = fin4 ? fp4 : (son ? sf4 : 32'sd0);
  assign d4  = {pf4[31], pf4} - {pb4[31], pb4};

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: capture, clamp theta
      d1  <= in_data;
      th1 <= (in_data.wet_weight < wfloor) ? wfloor : in_data.wet_weight;
      z1  <= in_data.edge_face || (in_data.open_weight == '0) ||
             (in_data.wet_weight == '0);
      // stage 2: blend products
      ba2  <= d1.back_surface_pressure  * wgt1;
      bb2  <= d1.front_surface_pressure * th1s;
      fa2  <= d1.front_surface_pressure * wgt1;
      fb2  <= d1.back_surface_pressure  * th1s;
      th2  <= th1;
      sd2  <= '{old_velocity: d1.old_velocity, neg: 1'b0, zero: z1};
      bin2 <= d1.back_inside;  bp2 <= d1.back_pressure;
      fin2 <= d1.front_inside; fp2 <= d1.front_pressure;
      // stage 3: floor shift, saturate
      bl3  <= sat32(64'(sumb >>> 16));
      fl3  <= sat32(64'(sumf >>> 16));
      th3  <= th2; sd3 <= sd2;
      bin3 <= bin2; bp3 <= bp2; fin3 <= fin2; fp3 <= fp2;
      // stage 4: surface scale
      bm4  <= bl3 * scale;
      fm4  <= fl3 * scale;
      th4  <= th3; sd4 <= sd3;
      bin4 <= bin3; bp4 <= bp3; fin4 <= fin3; fp4 <= fp3;
      // stage 5: side pressures, difference, magnitude
      mag5     <= d4[32] ? 33'(-d4) : 33'(d4);
      th5      <= th4;
      sd5      <= '{old_velocity: sd4.old_velocity, neg: d4[32], zero: sd4.zero};
      // stage 6: |d| * dt/dx in two halves
      plo6 <= mag5 * sos[15:0];
      phi6 <= mag5 * sos[31:16];
      th6  <= th5; sd6 <= sd5;
      // stage 7: join partial products
      num7 <= 65'(plo6) + {phi6, 16'b0};
      th7  <= th6; sd7 <= sd6;
    end
  end

  logic               dv;
  logic [DIV_Q_W-1:0] dq;
  logic               dovf;
  side_t              dside;

  fvpu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (v7),
    .num      (num7),
    .theta    (th7),
    .side_in  (sd7),
    .out_v    (dv),
    .q        (dq),
    .ovf      (dovf),
    .side_out (dside)
  );

  // guard bits of the quotient drop here
  logic [34:0]        term;
  logic signed [36:0] nv;
  assign term = dovf ? 35'h400000000 : {1'b0, dq[DIV_Q_W-1:2]};
  assign nv   = 37'(dside.old_velocity) -
                (dside.neg ? -$signed({2'b00, term}) : $signed({2'b00, term}));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dside.zero) begin
        out_data <= '{new_velocity: 32'sd0, face_valid: 1'b0};
      end else begin
        out_data <= '{new_velocity: sat32(64'(nv)), face_valid: 1'b1};
      end
    end
  end

endmodule

### design/fvpu_checker.sv
// ----------------------------------------------------------------------------
// fvpu_checker
// Port-level assertions for the face velocity pressure update.
// ----------------------------------------------------------------------------
module fvpu_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input fvpu_pkg::out_t                   out_data,
  input logic                             cfg_ready
);
  import fvpu_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output item changed");

  a_zero_face: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.face_valid |-> out_data.new_velocity == 32'sd0)
    else $error("zeroed face with nonzero velocity");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while output free");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind face_velocity_pressure_update fvpu_checker u_fvpu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives grid faces into face_velocity_pressure_update under random gaps and
// output stalls and checks each projected velocity against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
  import fvpu_pkg::*;

  localparam int LATENCY   = 18;
  localparam int MAX_CYCLE = 400000;
  localparam logic [CFG_INDEX_W-1:0] REG_PAST_LIST = 8'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  face_velocity_pressure_update i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers
  logic [31:0] dt_dx;
  logic signed [31:0] surf_scale;
  logic surf_on;
  logic [16:0] w_floor;

  out_t velocity_q[$];
  int errors = 0;
  int faces_sent = 0;
  int faces_checked = 0;
  int cycle = 0;
  int hold_cycles = 0;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("timeout at cycle %0d", cycle);
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint surface_blend(longint near_p, longint far_p, longint theta);
    longint mix;
    mix = clip32(floor16(near_p * (65536 - theta) + far_p * theta));
    return clip32(floor16(mix * longint'(surf_scale)));
  endfunction

  function automatic out_t project_face(in_t f);
    out_t r;
    longint theta, pb, pf, d, term, nv;
    logic [63:0] mag, g;
    r = '0;
    if (f.edge_face || f.open_weight == 0 || f.wet_weight == 0) return r;
    theta = (f.wet_weight < w_floor) ? w_floor : f.wet_weight;
    pb = 0;
    pf = 0;
    if (f.back_inside) pb = f.back_pressure;
    else if (surf_on) pb = surface_blend(f.back_surface_pressure,
                                         f.front_surface_pressure, theta);
    if (f.front_inside) pf = f.front_pressure;
    else if (surf_on) pf = surface_blend(f.front_surface_pressure,
                                         f.back_surface_pressure, theta);
    d = pf - pb;
    mag = (d < 0) ? -d : d;
    g = (mag * {32'd0, dt_dx}) / theta;
    if (g > 64'd17179869184) g = 64'd17179869184;
    term = (d < 0) ? -longint'(g) : longint'(g);
    nv = clip32(longint'(f.old_velocity) - term);
    r.new_velocity = nv[31:0];
    r.face_valid = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string what, out_t got, out_t want);
    errors++;
    $display("mismatch %s at cycle %0d: got v=%0d valid=%0b want v=%0d valid=%0b",
             what, cycle, got.new_velocity, got.face_valid,
             want.new_velocity, want.face_valid);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      faces_checked <= faces_checked + 1;
      if (velocity_q.size() == 0) begin
        report_mismatch("unexpected", out_data, '0);
      end else begin
        want = velocity_q.pop_front();
        if (out_data.new_velocity !== want.new_velocity)
          report_mismatch("new_velocity", out_data, want);
        if (out_data.face_valid !== want.face_valid)
          report_mismatch("face_valid", out_data, want);
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!out_ready || out_valid) begin
      if ($urandom_range(3) == 0) begin
        stall_left <= $urandom_range(7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  bit no_gaps = 1'b0;

  // valid stays up into the next item; a gap or drain() drops it
  task automatic send_face(in_t f);
    int gap;
    gap = no_gaps ? 0 : (($urandom_range(1) == 0) ? 0 : $urandom_range(7));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    velocity_q.push_back(project_face(f));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    faces_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (velocity_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_STEP_OVER_SPACING: dt_dx = val;
      REG_SURFACE_SCALE:     surf_scale = val;
      REG_SURFACE_ON:        surf_on = val[0];
      REG_WEIGHT_FLOOR:      w_floor = val[16:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(5))
      0: return 17'd65536;
      1: return 17'($urandom_range(1000));
      2: return 17'($urandom);  // above one allowed
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic in_t rand_face();
    in_t f;
    f.edge_face = ($urandom_range(9) == 0);
    f.open_weight = ($urandom_range(9) == 0) ? 17'd0 : rand_weight();
    f.wet_weight = ($urandom_range(9) == 0) ? 17'd0 : rand_weight();
    f.old_velocity = rand_value();
    f.back_inside = 1'($urandom_range(1));
    f.back_pressure = rand_value();
    f.back_surface_pressure = rand_value();
    f.front_inside = 1'($urandom_range(1));
    f.front_pressure = rand_value();
    f.front_surface_pressure = rand_value();
    return f;
  endfunction

  task automatic test_directed();
    in_t f;
    f = '0;
    f.open_weight = 17'd65536;
    f.wet_weight = 17'd65536;
    f.back_inside = 1'b1;
    f.front_inside = 1'b1;
    f.front_pressure = 32'sd65536;
    send_face(f);
    f.edge_face = 1'b1; send_face(f);
    f.edge_face = 1'b0; f.open_weight = 17'd0; send_face(f);
    f.open_weight = 17'd65536; f.wet_weight = 17'd0; send_face(f);
    f.wet_weight = 17'd1; send_face(f);          // floored theta
    f.wet_weight = 17'h1ffff; send_face(f);      // weight above one
    f.old_velocity = 32'sh7fffffff; f.front_pressure = 32'sh80000000;
    f.back_pressure = 32'sh7fffffff; send_face(f);
    f.old_velocity = 32'sh80000000; f.front_pressure = 32'sh7fffffff;
    f.back_pressure = 32'sh80000000; f.wet_weight = 17'd1; send_face(f);
    f.back_inside = 1'b0; f.front_inside = 1'b0; send_face(f);
    drain();
    write_reg(REG_SURFACE_ON, 32'd1);
    write_reg(REG_WEIGHT_FLOOR, 32'd0);          // no floor
    f.back_surface_pressure = 32'sh7fffffff;
    f.front_surface_pressure = 32'sh80000000;
    send_face(f);
    f.wet_weight = 17'h1ffff; send_face(f);
    f.wet_weight = 17'd32768; f.back_inside = 1'b1; send_face(f);
    f.back_inside = 1'b0; f.front_inside = 1'b1; send_face(f);
    drain();
    write_reg(REG_STEP_OVER_SPACING, 32'hffffffff);
    write_reg(REG_SURFACE_SCALE, 32'h80000000);
    f.front_inside = 1'b0; f.wet_weight = 17'd1; send_face(f);
    drain();
    write_reg(REG_PAST_LIST, 32'hdeadbeef);      // index past the list
    f.wet_weight = 17'd65536; send_face(f);
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) send_face(rand_face());
  endtask

  task automatic test_settings();
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_STEP_OVER_SPACING, 32'd65536);
          write_reg(REG_SURFACE_SCALE, 32'd65536);
          write_reg(REG_SURFACE_ON, 32'd0);
          write_reg(REG_WEIGHT_FLOOR, 32'd655);
        end
        1: write_reg(REG_SURFACE_ON, 32'd1);
        2: begin
          write_reg(REG_STEP_OVER_SPACING, 32'd0);
          write_reg(REG_SURFACE_SCALE, 32'h7fffffff);
          write_reg(REG_WEIGHT_FLOOR, 32'd65536);
        end
        3: begin
          write_reg(REG_STEP_OVER_SPACING, 32'hffffffff);
          write_reg(REG_SURFACE_SCALE, 32'h80000000);
          write_reg(REG_WEIGHT_FLOOR, 32'd1);
        end
        default: begin
          write_reg(REG_STEP_OVER_SPACING, $urandom);
          write_reg(REG_SURFACE_SCALE, $urandom);
          write_reg(REG_SURFACE_ON, $urandom);
          write_reg(REG_WEIGHT_FLOOR, $urandom_range(65536));
        end
      endcase
      test_random(130);
    end
  endtask

  task automatic test_backpressure();
    drain();
    // long receiver hold-off while the sender streams back to back
    @(posedge clk);
    hold_cycles <= 60;
    no_gaps = 1'b1;
    test_random(80);
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    dt_dx = STEP_OVER_SPACING_RESET;
    surf_scale = SURFACE_SCALE_RESET;
    surf_on = 1'b0;
    w_floor = WEIGHT_FLOOR_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    test_backpressure();
    drain();
    $display("covered %0d faces, %0d results checked, over edge, zero-weight,",
             faces_sent, faces_checked);
    $display("floor, surface blend and saturation cases with output stalls");
    if (errors == 0 && velocity_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
design/fvpu_pkg.sv
design/fvpu_div.sv
design/face_velocity_pressure_update.sv
design/fvpu_checker.sv
dv/testbench.sv
